[sv/bmfa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the block map file allocator.
// No dependencies; every other file of the block imports this package.
package bmfa_pkg;

  localparam int OWNER_W    = 8;
  localparam int IDX_W      = 10;
  localparam int BIU_W      = 11;
  localparam int NEED_W     = 12;
  localparam int MAP_AW_MAX = 16;
  localparam int CFG_IW     = 2;

  localparam logic [1:0] ACT_MARK  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic [1:0] MODE_CONTIG  = 2'd0;
  localparam logic [1:0] MODE_LINKED  = 2'd1;
  localparam logic [1:0] MODE_INDEXED = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BLOCKS = 2'd1;

  localparam logic [OWNER_W-1:0] OWNER_FREE  = 8'd0;
  localparam logic [OWNER_W-1:0] OWNER_FIXED = 8'd255;

  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]         action;
    logic [IDX_W-1:0]   block_index;
    logic [OWNER_W-1:0] owner_id;
    logic [BIU_W-1:0]   block_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   first_block;
    logic [IDX_W-1:0]   index_block;
    logic [OWNER_W-1:0] owner_read;
  } out_word_t;

  typedef struct packed {
    logic                  we;
    logic [MAP_AW_MAX-1:0] waddr;
    logic [OWNER_W-1:0]    wdata;
    logic [MAP_AW_MAX-1:0] raddr;
  } map_req_t;

endpackage

[sv/block_map_file_allocator_core.sv]
`timescale 1ns / 1ps
// Block map file allocator: an owner map of NUM_BLOCKS entries, marked,
// read and allocated in contiguous, linked or indexed mode.
// Input words arrive on in_valid/in_ready, result words leave on
// out_valid/out_ready, one result word for each input word, in order.
// Configuration words (cfg_index 0: allocation mode, 1: blocks in use) are
// taken on cfg_valid/cfg_ready at any time; cfg_ready is always high.
// After reset the owner map is cleared one entry per cycle, and no input
// word is taken during that pass. The block then handles one input word at
// a time. An allocation scans the map through the single read port of the
// map memory, one entry per cycle, until the request is met, then walks the
// chosen span again writing the owner.
// A finished result sits in the output register; the next input word is
// taken while it waits, and a stalled receiver only holds the sequencer once
// a second result is ready.
module block_map_file_allocator_core #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bmfa_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bmfa_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmfa_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bmfa_pkg::BIU_W-1:0]    cfg_data
);
  import bmfa_pkg::*;

  logic [1:0]         alloc_mode;
  logic [BIU_W-1:0]   blocks_in_use;
  logic               res_valid;
  logic               res_ready;
  out_word_t          res_word;
  map_req_t           mem_req;
  logic [OWNER_W-1:0] rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_mode    <= MODE_CONTIG;
      blocks_in_use <= BIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   alloc_mode    <= cfg_data[1:0];
        CFG_BLOCKS: blocks_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res_word;
    end
  end

  bmfa_seq #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .alloc_mode    (alloc_mode),
    .blocks_in_use (blocks_in_use),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_word      (res_word),
    .mem_req       (mem_req),
    .rdata         (rdata)
  );

  bmfa_map_ram #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_map_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

`ifndef SYNTH
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during the clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer took a second word while busy");

  a_fail_zero_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_DONE |->
      out_word.first_block == '0 && out_word.index_block == '0 && out_word.owner_read == '0)
    else $error("failed request reports nonzero fields");

  a_no_result_unasked: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !in_ready)
    else $error("result pending while sequencer idle");
`endif

endmodule

[sv/bmfa_map_ram.sv]
`timescale 1ns / 1ps
// Owner map storage: one write port and one registered read port.
// Depends on bmfa_pkg for the request struct.
module bmfa_map_ram #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                           clk,
  input  bmfa_pkg::map_req_t             req,
  output logic [bmfa_pkg::OWNER_W-1:0]   rdata
);
  import bmfa_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);

  logic [OWNER_W-1:0] mem [0:NUM_BLOCKS-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

[sv/bmfa_seq.sv]
`timescale 1ns / 1ps
// Sequencer of the allocator: clearing pass, mark, read, scan and fill passes.
// One address counter (clear, scan, fill), one free compare (scan, fill).
// Depends on bmfa_pkg.
module bmfa_seq #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bmfa_pkg::in_word_t            in_word,
  input  logic [1:0]                    alloc_mode,
  input  logic [bmfa_pkg::BIU_W-1:0]    blocks_in_use,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bmfa_pkg::out_word_t           res_word,
  output bmfa_pkg::map_req_t            mem_req,
  input  logic [bmfa_pkg::OWNER_W-1:0]  rdata
);
  import bmfa_pkg::*;

  localparam int LW = ($clog2(NUM_BLOCKS + 1) > BIU_W) ? $clog2(NUM_BLOCKS + 1) : BIU_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]         state, state_next;
  logic [1:0]         act_r, act_r_next;
  logic [IDX_W-1:0]   idx_r, idx_r_next;
  logic [OWNER_W-1:0] owner_r, owner_r_next;
  logic [BIU_W-1:0]   count_r, count_r_next;
  logic [NEED_W-1:0]  need_r, need_r_next;
  logic               contig_r, contig_r_next;
  logic [LW-1:0]      ptr, ptr_next;
  logic [LW-1:0]      paddr, paddr_next;
  logic               pv, pv_next;
  logic [NEED_W-1:0]  cnt, cnt_next;
  logic [LW-1:0]      start, start_next;
  logic [LW-1:0]      first_r, first_r_next;
  logic [LW-1:0]      last_r, last_r_next;
  out_word_t          res_r, res_r_next;

  logic [LW-1:0] lim;
  logic          idx_ok;
  logic          free;
  logic [LW-1:0] run_first;

  assign lim = (LW'(blocks_in_use) > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : LW'(blocks_in_use);
  assign idx_ok    = LW'(idx_r) < lim;
  assign free      = rdata == OWNER_FREE;
  assign run_first = (cnt == '0) ? paddr : start;

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_FINISH;
  assign res_word  = res_r;

  always_comb begin
    state_next    = state;
    act_r_next    = act_r;
    idx_r_next    = idx_r;
    owner_r_next  = owner_r;
    count_r_next  = count_r;
    need_r_next   = need_r;
    contig_r_next = contig_r;
    ptr_next      = ptr;
    paddr_next    = paddr;
    pv_next       = pv;
    cnt_next      = cnt;
    start_next    = start;
    first_r_next  = first_r;
    last_r_next   = last_r;
    res_r_next    = res_r;
    mem_req       = '0;
    mem_req.raddr = MAP_AW_MAX'(ptr);

    case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = MAP_AW_MAX'(ptr);
        mem_req.wdata = OWNER_FREE;
        ptr_next      = ptr + LW'(1);
        if (ptr == LW'(NUM_BLOCKS - 1)) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_r_next   = in_word.action;
          idx_r_next   = in_word.block_index;
          owner_r_next = in_word.owner_id;
          count_r_next = in_word.block_count;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_r_next        = '0;
        res_r_next.status = ST_BAD;
        state_next        = S_FINISH;
        case (act_r)
          ACT_MARK: begin
            if (idx_ok) begin
              mem_req.we        = 1'b1;
              mem_req.waddr     = MAP_AW_MAX'(idx_r);
              mem_req.wdata     = OWNER_FIXED;
              res_r_next.status = ST_DONE;
            end
          end
          ACT_READ: begin
            if (idx_ok) begin
              mem_req.raddr = MAP_AW_MAX'(idx_r);
              state_next    = S_RDWAIT;
            end
          end
          ACT_ALLOC: begin
            if (count_r != '0 && owner_r != OWNER_FREE && owner_r != OWNER_FIXED &&
                alloc_mode inside {MODE_CONTIG, MODE_LINKED, MODE_INDEXED}) begin
              need_r_next   = NEED_W'(count_r) + NEED_W'(alloc_mode == MODE_INDEXED);
              contig_r_next = alloc_mode == MODE_CONTIG;
              ptr_next      = '0;
              pv_next       = 1'b0;
              cnt_next      = '0;
              state_next    = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        res_r_next.status     = ST_DONE;
        res_r_next.owner_read = rdata;
        state_next            = S_FINISH;
      end
      S_SCAN: begin
        if (ptr < lim) begin
          ptr_next   = ptr + LW'(1);
          paddr_next = ptr;
          pv_next    = 1'b1;
        end else begin
          pv_next = 1'b0;
        end
        if (pv) begin
          if (free) begin
            if (cnt == '0) begin
              start_next = paddr;
            end
            cnt_next = cnt + NEED_W'(1);
            if (cnt + NEED_W'(1) == need_r) begin
              first_r_next = run_first;
              last_r_next  = paddr;
              ptr_next     = run_first;
              pv_next      = 1'b0;
              state_next   = S_FILL;
            end
          end else if (contig_r) begin
            cnt_next = '0;
          end
        end else if (ptr >= lim) begin
          res_r_next.status = ST_NOSPACE;
          state_next        = S_FINISH;
        end
      end
      S_FILL: begin
        if (ptr <= last_r) begin
          ptr_next   = ptr + LW'(1);
          paddr_next = ptr;
          pv_next    = 1'b1;
        end else begin
          pv_next = 1'b0;
        end
        if (pv && free) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = MAP_AW_MAX'(paddr);
          mem_req.wdata = owner_r;
        end
        if (!pv && ptr > last_r) begin
          res_r_next.status      = ST_DONE;
          res_r_next.first_block = IDX_W'(first_r);
          res_r_next.index_block = IDX_W'(last_r);
          state_next             = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      pv    <= pv_next;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_r_next;
    idx_r    <= idx_r_next;
    owner_r  <= owner_r_next;
    count_r  <= count_r_next;
    need_r   <= need_r_next;
    contig_r <= contig_r_next;
    paddr    <= paddr_next;
    cnt      <= cnt_next;
    start    <= start_next;
    first_r  <= first_r_next;
    last_r   <= last_r_next;
    res_r    <= res_r_next;
  end

endmodule

[test/tb_block_map_file_allocator_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_map_file_allocator_core: directed table, then random phases.
// Each result word is checked against a fixed table word or a lockstep owner-map predictor.
// Depends on bmfa_pkg and the core RTL only.
module tb_block_map_file_allocator_core;
  import bmfa_pkg::*;

  localparam int MAP_SIZE = 1024;
  localparam int PHASE_WORDS = 30;
  localparam int NUM_PHASES = 9;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    in_word_t           word;
    logic [CFG_IW-1:0]  reg_idx;
    logic [BIU_W-1:0]   reg_val;
    logic               typed;
    out_word_t          want;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_word_t in_word;
  out_word_t out_word;
  logic [CFG_IW-1:0] cfg_index;
  logic [BIU_W-1:0] cfg_data;

  logic [OWNER_W-1:0] owner_tab [MAP_SIZE];
  logic [1:0] mode_copy;
  logic [BIU_W-1:0] usable_copy;
  out_word_t pending_results[$];
  dir_row_t rows[$];
  int errors, results_seen, words_sent, grants, refusals;
  bit no_gaps;

  logic [1:0] phase_mode [NUM_PHASES] = '{MODE_CONTIG, MODE_LINKED, MODE_INDEXED,
                                          MODE_CONTIG, MODE_LINKED, MODE_INDEXED,
                                          MODE_CONTIG, MODE_LINKED, MODE_INDEXED};
  logic [BIU_W-1:0] phase_blocks [NUM_PHASES] = '{11'd64, 11'd128, 11'd200, 11'd2047,
                                                  11'd1024, 11'd512, 11'd1, 11'd1024,
                                                  11'd1024};

  block_map_file_allocator_core #(.NUM_BLOCKS(MAP_SIZE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic add_row(dir_row_t r);
    rows.insert(rows.size(), r);
  endtask

  task automatic queue_result(out_word_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  function automatic out_word_t allocator_result(in_word_t w);
    out_word_t r;
    int lim, need, run, start, first, last;
    bit found;
    r = '0;
    r.status = ST_BAD;
    lim = (usable_copy > MAP_SIZE) ? MAP_SIZE : int'(usable_copy);
    found = 0;
    run = 0;
    start = 0;
    first = 0;
    last = 0;
    if (w.action == ACT_MARK) begin
      if (int'(w.block_index) < lim) begin
        owner_tab[w.block_index] = OWNER_FIXED;
        r.status = ST_DONE;
      end
    end else if (w.action == ACT_READ) begin
      if (int'(w.block_index) < lim) begin
        r.owner_read = owner_tab[w.block_index];
        r.status = ST_DONE;
      end
    end else if (w.action == ACT_ALLOC && w.block_count != 0 && w.owner_id != OWNER_FREE &&
                 w.owner_id != OWNER_FIXED && mode_copy <= MODE_INDEXED) begin
      need = int'(w.block_count) + ((mode_copy == MODE_INDEXED) ? 1 : 0);
      for (int b = 0; b < lim && !found; b++) begin
        if (owner_tab[b] == OWNER_FREE) begin
          if (run == 0) start = b;
          run++;
          if (run == need) begin
            found = 1;
            first = start;
            last = b;
          end
        end else if (mode_copy == MODE_CONTIG) begin
          run = 0;
        end
      end
      if (found) begin
        for (int b = first; b <= last; b++)
          if (owner_tab[b] == OWNER_FREE) owner_tab[b] = w.owner_id;
        r.status = ST_DONE;
        r.first_block = IDX_W'(first);
        r.index_block = IDX_W'(last);
      end else begin
        r.status = ST_NOSPACE;
      end
    end
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int lim, pick, sub;
    lim = (usable_copy > MAP_SIZE) ? MAP_SIZE : int'(usable_copy);
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 19);
    w.block_index = IDX_W'($urandom_range(0, MAP_SIZE - 1));
    w.owner_id = OWNER_W'($urandom_range(1, 254));
    w.block_count = BIU_W'($urandom_range(1, 6));
    if (lim > 0 && $urandom_range(0, 99) < 85)
      w.block_index = IDX_W'($urandom_range(0, lim - 1));
    if (pick < 40) begin
      w.action = ACT_ALLOC;
      if (sub == 0) w.block_count = '0;
      else if (sub == 1) w.owner_id = $urandom_range(0, 1) ? OWNER_FIXED : OWNER_FREE;
      else if (sub == 2) w.block_count = BIU_W'($urandom_range(1024, 2047));
      else if (sub < 5) w.block_count = BIU_W'($urandom_range(7, 40));
    end else if (pick < 70) begin
      w.action = ACT_READ;
    end else if (pick < 92) begin
      w.action = ACT_MARK;
    end else begin
      w.action = ACT_SPARE;
    end
    return w;
  endfunction

  function automatic dir_row_t item_row(logic [1:0] act, int idx, int own, int cnt);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.word.action = act;
    r.word.block_index = IDX_W'(idx);
    r.word.owner_id = OWNER_W'(own);
    r.word.block_count = BIU_W'(cnt);
    return r;
  endfunction

  function automatic dir_row_t known_row(logic [1:0] act, int idx, int own, int cnt,
                                         logic [1:0] st, int rd);
    dir_row_t r;
    r = item_row(act, idx, own, cnt);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.owner_read = OWNER_W'(rd);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IW-1:0] idx, int val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = BIU_W'(val);
    return r;
  endfunction

  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    int gap;
    out_word_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    r = allocator_result(w);
    if (w.action == ACT_ALLOC && r.status == ST_DONE) grants++;
    if (r.status == ST_NOSPACE) refusals++;
    queue_result(typed ? want : r);
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [BIU_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODE) mode_copy = val[1:0];
    else if (idx == CFG_BLOCKS) usable_copy = val;
  endtask

  initial begin
    int gap;
    out_word_t want;
    @(posedge clk);
    forever begin
      if (results_seen == 40 || results_seen == 180) gap = HOLD_CYCLES;
      else gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status || out_word.first_block !== want.first_block ||
            out_word.index_block !== want.index_block ||
            out_word.owner_read !== want.owner_read) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch at result %0d: expected st=%0d first=%0d last=%0d own=%0d,",
                      " got st=%0d first=%0d last=%0d own=%0d"},
                     results_seen, want.status, want.first_block, want.index_block,
                     want.owner_read, out_word.status, out_word.first_block,
                     out_word.index_block, out_word.owner_read);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("tb_block_map_file_allocator_core: errors");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_gaps = 0;
    errors = 0;
    results_seen = 0;
    words_sent = 0;
    grants = 0;
    refusals = 0;
    for (int b = 0; b < MAP_SIZE; b++) owner_tab[b] = OWNER_FREE;
    mode_copy = MODE_CONTIG;
    usable_copy = BIU_RESET;

    add_row(known_row(ACT_READ, 0, 1, 1, ST_DONE, OWNER_FREE));
    add_row(known_row(ACT_READ, 1023, 1, 1, ST_DONE, OWNER_FREE));
    add_row(known_row(ACT_SPARE, 1023, 255, 2047, ST_BAD, 0));
    add_row(known_row(ACT_ALLOC, 0, 9, 0, ST_BAD, 0));
    add_row(known_row(ACT_ALLOC, 0, OWNER_FREE, 1, ST_BAD, 0));
    add_row(known_row(ACT_ALLOC, 0, OWNER_FIXED, 1, ST_BAD, 0));
    add_row(cfg_row(CFG_BLOCKS, 16));
    add_row(known_row(ACT_READ, 16, 1, 1, ST_BAD, 0));
    add_row(known_row(ACT_MARK, 16, 1, 1, ST_BAD, 0));
    add_row(known_row(ACT_MARK, 3, 1, 1, ST_DONE, 0));
    add_row(item_row(ACT_ALLOC, 0, 1, 3));
    add_row(item_row(ACT_ALLOC, 0, 254, 4));
    add_row(known_row(ACT_ALLOC, 0, 2, 2047, ST_NOSPACE, 0));
    add_row(cfg_row(CFG_MODE, MODE_LINKED));
    add_row(item_row(ACT_ALLOC, 0, 5, 4));
    add_row(item_row(ACT_MARK, 9, 1, 1));
    add_row(known_row(ACT_READ, 9, 1, 1, ST_DONE, OWNER_FIXED));
    add_row(item_row(ACT_ALLOC, 0, 6, 5));
    add_row(cfg_row(CFG_MODE, MODE_INDEXED));
    add_row(item_row(ACT_ALLOC, 0, 7, 3));
    add_row(item_row(ACT_READ, 15, 1, 1));
    add_row(cfg_row(CFG_MODE, MODE_SPARE));
    add_row(known_row(ACT_ALLOC, 0, 8, 1, ST_BAD, 0));
    add_row(cfg_row(CFG_BLOCKS, 0));
    add_row(known_row(ACT_READ, 0, 1, 1, ST_BAD, 0));
    add_row(cfg_row(CFG_MODE, MODE_CONTIG));
    add_row(item_row(ACT_ALLOC, 0, 3, 1));
    add_row(cfg_row(CFG_SPARE, 2047));
    add_row(cfg_row(CFG_BLOCKS, 2047));
    add_row(known_row(ACT_READ, 1023, 1, 1, ST_DONE, OWNER_FREE));
    add_row(known_row(ACT_MARK, 1023, 1, 1, ST_DONE, 0));
    add_row(item_row(ACT_ALLOC, 0, 170, 1024));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_word(rows[i].word, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      no_gaps = (p % 3 == 1);
      write_reg(CFG_MODE, BIU_W'(phase_mode[p]));
      write_reg(CFG_BLOCKS, phase_blocks[p]);
      repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words through %0d mode/size settings; %0d results checked.",
             words_sent, NUM_PHASES + 1, results_seen);
    $display("Allocations granted: %0d, refused for lack of space: %0d.", grants, refusals);
    if (errors == 0) begin
      $display("tb_block_map_file_allocator_core: clean");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("tb_block_map_file_allocator_core: errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/bmfa_pkg.sv
sv/bmfa_map_ram.sv
sv/bmfa_seq.sv
sv/block_map_file_allocator_core.sv
test/tb_block_map_file_allocator_core.sv
